@@ rtl/link_handle_translation_table_top_defines.svh @@
// assertion macros for the link handle translation table
`ifndef LINK_HANDLE_TRANSLATION_TABLE_TOP_DEFINES_SVH
`define LINK_HANDLE_TRANSLATION_TABLE_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LHTT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in link handle table");

// antecedent implies consequent in the next cycle
`define LHTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in link handle table");

// condition holds at every edge out of reset
`define LHTT_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed in link handle table");

`endif

@@ rtl/lhtt_pkg.sv @@
// shared types and constants for the link handle translation table
`default_nettype none

package lhtt_pkg;

   localparam int HANDLE_W        = 12;
   localparam int FLAGS_W         = 4;
   localparam int EVT_W           = 8;
   localparam int STATUS_W        = 2;
   localparam int REQ_W           = 3;
   localparam int DEFAULT_ENTRIES = 32;

   localparam logic [HANDLE_W-1:0] VIRT_STEP_MASK = 12'h0EFF;

   typedef enum logic [REQ_W-1:0] {
      REQ_CONNECT     = 3'd0,
      REQ_DISCONNECT  = 3'd1,
      REQ_REMOVE_VIRT = 3'd2,
      REQ_PHYS_TO_VIRT = 3'd3,
      REQ_VIRT_TO_PHYS = 3'd4,
      REQ_REMOVE_PHYS = 3'd5
   } lhtt_req_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_IGNORED   = 2'd3
   } lhtt_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN_FIRST,
      S_SCAN_SECOND
   } lhtt_state_type;

   // what the compare unit looks for on the current scan
   typedef struct packed {
      logic find_free;
      logic by_phys;
   } lhtt_mode_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] virt;
      logic [HANDLE_W-1:0] phys;
   } lhtt_entry_type;

endpackage

`default_nettype wire

@@ rtl/link_handle_translation_table_top.sv @@
// Link handle translation table: sequencer, valid map and handle counter.
// Ignored and unknown requests answer in the cycle after acceptance.
// Connect and lookups scan the table one entry a cycle through the single
// read port. Disconnect scans again when its first scan hits.
// busy stays high until the result strobe.
// Reset clears the valid map and the handle counter at once, no sweep.
`default_nettype none

module link_handle_translation_table_top #(
   parameter int TABLE_ENTRIES = lhtt_pkg::DEFAULT_ENTRIES
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire  [lhtt_pkg::REQ_W-1:0]         req_type,
   input  wire  [lhtt_pkg::HANDLE_W-1:0]      req_handle_in,
   input  wire  [lhtt_pkg::FLAGS_W-1:0]       req_flags_in,
   input  wire  [lhtt_pkg::EVT_W-1:0]         req_event_status,
   output logic                               rsp_strobe,
   output logic [lhtt_pkg::HANDLE_W-1:0]      rsp_handle_out,
   output logic [lhtt_pkg::FLAGS_W-1:0]       rsp_flags_out,
   output logic [lhtt_pkg::STATUS_W-1:0]      rsp_status
);
   import lhtt_pkg::*;

   `include "link_handle_translation_table_top_defines.svh"

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);

   lhtt_state_type        state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  chk_ff, chk_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic [HANDLE_W-1:0]   key_ff, key_in;
   logic [HANDLE_W-1:0]   hout_ff, hout_in;
   logic [REQ_W-1:0]      type_ff, type_in;
   lhtt_mode_type         mode_ff, mode_in;
   logic [FLAGS_W-1:0]    flags_ff, flags_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [HANDLE_W-1:0]   next_virt_ff, next_virt_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [FLAGS_W-1:0]    rsp_flags_ff, rsp_flags_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic                  immediate;
   logic                  scanning;
   logic                  hit;
   logic                  miss;
   logic [HANDLE_W-1:0]   other_handle;
   logic                  wr_en;
   logic [IDX_W-1:0]      rd_addr;
   lhtt_entry_type        wr_data;
   lhtt_entry_type        rd_data;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign scanning = (state_ff == S_SCAN_FIRST) || (state_ff == S_SCAN_SECOND);

   // requests answered without touching the table
   always_comb begin
      immediate = 1'b0;
      if (!(req_type inside {[REQ_CONNECT:REQ_REMOVE_PHYS]})) begin
         immediate = 1'b1;
      end else if ((req_type inside {REQ_CONNECT, REQ_DISCONNECT}) &&
                   (req_event_status != '0)) begin
         immediate = 1'b1;
      end
   end

   lhtt_table #(
      .ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (chk_idx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lhtt_match u_match (
      .chk_live     (chk_ff && scanning),
      .entry_valid  (valid_ff[chk_idx_ff]),
      .mode         (mode_ff),
      .key          (key_ff),
      .entry        (rd_data),
      .hit          (hit),
      .other_handle (other_handle)
   );

   assign miss = chk_ff && scanning && !hit && (chk_idx_ff == LAST_IDX);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && !immediate) begin
               state_in = S_SCAN_FIRST;
            end
         end
         S_SCAN_FIRST: begin
            if (hit) begin
               state_in = (type_ff == REQ_DISCONNECT) ? S_SCAN_SECOND : S_IDLE;
            end else if (miss) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN_SECOND: begin
            if (hit || miss) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and result
   always_comb begin
      cnt_in        = cnt_ff;
      chk_in        = 1'b0;
      chk_idx_in    = chk_idx_ff;
      key_in        = key_ff;
      hout_in       = hout_ff;
      type_in       = type_ff;
      mode_in       = mode_ff;
      flags_in      = flags_ff;
      valid_in      = valid_ff;
      next_virt_in  = next_virt_ff;
      rsp_strobe_in = 1'b0;
      rsp_handle_in = rsp_handle_ff;
      rsp_flags_in  = rsp_flags_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_data.virt  = hout_ff;
      wr_data.phys  = key_ff;
      rd_addr       = cnt_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in   = req_handle_in;
               type_in  = req_type;
               flags_in = req_flags_in;
               cnt_in   = '0;
               mode_in.find_free = (req_type == REQ_CONNECT);
               mode_in.by_phys   = (req_type inside {REQ_DISCONNECT, REQ_PHYS_TO_VIRT,
                                                    REQ_REMOVE_PHYS});
               if (immediate) begin
                  rsp_strobe_in = 1'b1;
                  rsp_handle_in = '0;
                  rsp_flags_in  = req_flags_in;
                  rsp_status_in = (req_type inside {REQ_CONNECT, REQ_DISCONNECT}) ?
                                  STAT_IGNORED : STAT_NOT_FOUND;
               end else if (req_type == REQ_CONNECT) begin
                  // counter steps even if the table turns out full
                  hout_in      = next_virt_ff;
                  next_virt_in = (next_virt_ff + 1'b1) & VIRT_STEP_MASK;
               end
            end
         end
         S_SCAN_FIRST, S_SCAN_SECOND: begin
            // issue the next read; its compare happens in the next cycle
            if (cnt_ff < CNT_END) begin
               chk_in     = 1'b1;
               chk_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
            if (hit && state_ff == S_SCAN_SECOND) begin
               valid_in[chk_idx_ff] = 1'b0;
               rsp_strobe_in = 1'b1;
               rsp_handle_in = hout_ff;
               rsp_flags_in  = flags_ff;
               rsp_status_in = STAT_OK;
            end else if (hit) begin
               case (type_ff)
                  REQ_CONNECT: begin
                     wr_en = 1'b1;
                     valid_in[chk_idx_ff] = 1'b1;
                     rsp_strobe_in = 1'b1;
                     rsp_handle_in = hout_ff;
                     rsp_flags_in  = flags_ff;
                     rsp_status_in = STAT_OK;
                  end
                  REQ_DISCONNECT: begin
                     // second pass frees the lowest entry holding this virtual handle
                     key_in          = rd_data.virt;
                     hout_in         = rd_data.virt;
                     mode_in.by_phys = 1'b0;
                     cnt_in          = '0;
                     chk_in          = 1'b0;
                  end
                  REQ_REMOVE_VIRT, REQ_REMOVE_PHYS: begin
                     valid_in[chk_idx_ff] = 1'b0;
                     rsp_strobe_in = 1'b1;
                     rsp_handle_in = other_handle;
                     rsp_flags_in  = flags_ff;
                     rsp_status_in = STAT_OK;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_handle_in = other_handle;
                     rsp_flags_in  = flags_ff;
                     rsp_status_in = STAT_OK;
                  end
               endcase
            end else if (miss) begin
               rsp_strobe_in = 1'b1;
               rsp_flags_in  = flags_ff;
               if (state_ff == S_SCAN_SECOND) begin
                  rsp_handle_in = hout_ff;
                  rsp_status_in = STAT_OK;
               end else begin
                  rsp_handle_in = '0;
                  rsp_status_in = (type_ff == REQ_CONNECT) ? STAT_FULL : STAT_NOT_FOUND;
               end
            end
         end
         default: begin
            chk_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         chk_ff        <= 1'b0;
         valid_ff      <= '0;
         next_virt_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_ff        <= chk_in;
         valid_ff      <= valid_in;
         next_virt_ff  <= next_virt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      chk_idx_ff    <= chk_idx_in;
      key_ff        <= key_in;
      hout_ff       <= hout_in;
      type_ff       <= type_in;
      mode_ff       <= mode_in;
      flags_ff      <= flags_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_flags_ff  <= rsp_flags_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_flags_out  = rsp_flags_ff;
   assign rsp_status     = rsp_status_ff;

   `LHTT_ASSERT_NEXT(a_immediate_rsp, clock, reset, accept && immediate, rsp_strobe_ff)
   `LHTT_ASSERT_IMPL(a_done_strobe, clock, reset, $fell(busy), rsp_strobe_ff)
   `LHTT_ASSERT_IMPL(a_connect_fills, clock, reset,
      rsp_strobe_ff && (rsp_status_ff == STAT_OK) && (type_ff == REQ_CONNECT) &&
      !$past(state_ff == S_IDLE),
      $countones(valid_ff) == $countones($past(valid_ff)) + 1)
   `LHTT_ASSERT_IMPL(a_second_pass_order, clock, reset, state_ff == S_SCAN_SECOND,
      ($past(state_ff) == S_SCAN_FIRST) || ($past(state_ff) == S_SCAN_SECOND))
   `LHTT_ASSERT_ALWAYS(a_counter_mask, clock, reset, next_virt_ff[8] == 1'b0)

endmodule

`default_nettype wire

@@ rtl/lhtt_table.sv @@
// handle pair storage: one write port, one registered read port
`default_nettype none

module lhtt_table #(
   parameter int ENTRIES = lhtt_pkg::DEFAULT_ENTRIES,
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [IDX_W-1:0]             wr_addr,
   input  lhtt_pkg::lhtt_entry_type     wr_data,
   input  wire  [IDX_W-1:0]             rd_addr,
   output lhtt_pkg::lhtt_entry_type     rd_data
);
   import lhtt_pkg::*;

   lhtt_entry_type entry_mem [ENTRIES];
   lhtt_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/lhtt_match.sv @@
// shared compare unit: tests one scanned entry for being free or against the search key
`default_nettype none

module lhtt_match (
   input  wire                                 chk_live,
   input  wire                                 entry_valid,
   input  lhtt_pkg::lhtt_mode_type             mode,
   input  wire  [lhtt_pkg::HANDLE_W-1:0]       key,
   input  lhtt_pkg::lhtt_entry_type            entry,
   output logic                                hit,
   output logic [lhtt_pkg::HANDLE_W-1:0]       other_handle
);
   import lhtt_pkg::*;

   logic [HANDLE_W-1:0] probe;

   always_comb begin
      probe = mode.by_phys ? entry.phys : entry.virt;
      if (mode.find_free) begin
         hit = chk_live && !entry_valid;
      end else begin
         hit = chk_live && entry_valid && (probe == key);
      end
      // a lookup returns the handle on the opposite side of the pair
      other_handle = mode.by_phys ? entry.virt : entry.phys;
   end

endmodule

`default_nettype wire

@@ tb/sv/tb_link_handle_translation_table_top.sv @@
// self-checking testbench for the link handle translation table top level
`default_nettype none

module tb_link_handle_translation_table_top;
   import lhtt_pkg::*;

   localparam int ENTRIES      = DEFAULT_ENTRIES;
   localparam int RANDOM_ITEMS = 800;
   localparam int PLAN_LEN     = 23;
   localparam int SETTLE_CYCLES = 2 * ENTRIES + 40;
   localparam int CYCLE_LIMIT  = 500000;

   // request codes the package leaves unnamed
   localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
   localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix;

   typedef struct {
      logic [REQ_W-1:0]    kind;
      logic [HANDLE_W-1:0] handle;
      logic [FLAGS_W-1:0]  flags;
      logic [EVT_W-1:0]    evt;
      bit                  fixed;
      logic [HANDLE_W-1:0] want_handle;
      lhtt_status_type     want_status;
   } stim_row;

   typedef struct {
      logic [HANDLE_W-1:0] handle;
      logic [FLAGS_W-1:0]  flags;
      lhtt_status_type     status;
   } table_result;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [REQ_W-1:0]    req_type = '0;
   logic [HANDLE_W-1:0] req_handle_in = '0;
   logic [FLAGS_W-1:0]  req_flags_in = '0;
   logic [EVT_W-1:0]    req_event_status = '0;
   logic                rsp_strobe;
   logic [HANDLE_W-1:0] rsp_handle_out;
   logic [FLAGS_W-1:0]  rsp_flags_out;
   logic [STATUS_W-1:0] rsp_status;

   link_handle_translation_table_top #(.TABLE_ENTRIES(ENTRIES)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_handle_in(req_handle_in),
      .req_flags_in(req_flags_in),
      .req_event_status(req_event_status),
      .rsp_strobe(rsp_strobe),
      .rsp_handle_out(rsp_handle_out),
      .rsp_flags_out(rsp_flags_out),
      .rsp_status(rsp_status)
   );

   always #6 clock = ~clock;

   // shadow copy of the table
   bit                  map_valid [ENTRIES];
   logic [HANDLE_W-1:0] map_virt [ENTRIES];
   logic [HANDLE_W-1:0] map_phys [ENTRIES];
   logic [HANDLE_W-1:0] next_virt = '0;

   table_result awaited_rsp [$];
   int errors = 0;
   int requests_sent = 0;
   int connects_done = 0;
   int full_hits = 0;
   int counter_wraps = 0;
   int earlier_frees = 0;
   int cycles = 0;

   stim_row plan [PLAN_LEN] = '{
      '{REQ_PHYS_TO_VIRT, 12'h000, 4'h0, 8'h00, 1'b1, 12'h000, STAT_NOT_FOUND},
      '{REQ_REMOVE_VIRT,  12'hFFF, 4'hF, 8'hFF, 1'b1, 12'h000, STAT_NOT_FOUND},
      '{REQ_CONNECT,      12'hFFF, 4'hF, 8'h00, 1'b1, 12'h000, STAT_OK},
      '{REQ_CONNECT,      12'h123, 4'hA, 8'h01, 1'b1, 12'h000, STAT_IGNORED},
      '{REQ_CONNECT,      12'h000, 4'h5, 8'h00, 1'b1, 12'h001, STAT_OK},
      '{REQ_CONNECT,      12'hFFF, 4'h0, 8'h00, 1'b1, 12'h002, STAT_OK},
      '{REQ_PHYS_TO_VIRT, 12'hFFF, 4'h3, 8'hFF, 1'b1, 12'h000, STAT_OK},
      '{REQ_VIRT_TO_PHYS, 12'h001, 4'hC, 8'h80, 1'b1, 12'h000, STAT_OK},
      '{REQ_VIRT_TO_PHYS, 12'h0FF, 4'h0, 8'h00, 1'b1, 12'h000, STAT_NOT_FOUND},
      '{REQ_DISCONNECT,   12'h000, 4'h1, 8'h80, 1'b1, 12'h000, STAT_IGNORED},
      '{REQ_DISCONNECT,   12'hFFF, 4'h2, 8'h00, 1'b1, 12'h000, STAT_OK},
      '{REQ_PHYS_TO_VIRT, 12'hFFF, 4'h4, 8'h00, 1'b1, 12'h002, STAT_OK},
      '{REQ_REMOVE_PHYS,  12'hFFF, 4'h8, 8'h00, 1'b1, 12'h002, STAT_OK},
      '{REQ_REMOVE_VIRT,  12'h001, 4'h6, 8'h00, 1'b1, 12'h000, STAT_OK},
      '{REQ_REMOVE_PHYS,  12'hABC, 4'h9, 8'h00, 1'b1, 12'h000, STAT_NOT_FOUND},
      '{REQ_DISCONNECT,   12'h555, 4'h7, 8'h00, 1'b1, 12'h000, STAT_NOT_FOUND},
      '{REQ_UNUSED_LO,    12'h7FF, 4'hF, 8'hFF, 1'b1, 12'h000, STAT_NOT_FOUND},
      '{REQ_UNUSED_HI,    12'h800, 4'h0, 8'h00, 1'b1, 12'h000, STAT_NOT_FOUND},
      '{REQ_CONNECT,      12'h800, 4'hB, 8'h00, 1'b0, 12'h000, STAT_OK},
      '{REQ_CONNECT,      12'h7FF, 4'hD, 8'h00, 1'b0, 12'h000, STAT_OK},
      '{REQ_REMOVE_PHYS,  12'h800, 4'hE, 8'h00, 1'b0, 12'h000, STAT_OK},
      '{REQ_CONNECT,      12'h400, 4'h1, 8'h00, 1'b0, 12'h000, STAT_OK},
      '{REQ_VIRT_TO_PHYS, 12'h005, 4'h2, 8'h40, 1'b0, 12'h000, STAT_OK}
   };

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycles, what, got, want);
   endtask

   // lowest valid entry keyed by physical or virtual handle, -1 if none
   function automatic int lowest_match(input bit by_phys, input logic [HANDLE_W-1:0] key);
      int hit;
      hit = -1;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (map_valid[i] && (by_phys ? map_phys[i] : map_virt[i]) == key)
            hit = i;
      end
      return hit;
   endfunction

   function automatic table_result apply_request(input logic [REQ_W-1:0] kind,
                                                 input logic [HANDLE_W-1:0] key,
                                                 input logic [FLAGS_W-1:0] flags,
                                                 input logic [EVT_W-1:0] evt);
      table_result res;
      int e;
      int f;
      logic [HANDLE_W-1:0] v;
      res.handle = '0;
      res.flags = flags;
      res.status = STAT_NOT_FOUND;
      case (kind)
         REQ_CONNECT: begin
            if (evt != 0) begin
               res.status = STAT_IGNORED;
            end else begin
               v = next_virt;
               next_virt = (next_virt + 1'b1) & VIRT_STEP_MASK;
               if (next_virt == 0)
                  counter_wraps++;
               connects_done++;
               e = -1;
               for (int i = ENTRIES - 1; i >= 0; i--)
                  if (!map_valid[i])
                     e = i;
               if (e < 0) begin
                  // handle is consumed even though nothing is stored
                  res.status = STAT_FULL;
                  full_hits++;
               end else begin
                  map_valid[e] = 1'b1;
                  map_virt[e] = v;
                  map_phys[e] = key;
                  res.handle = v;
                  res.status = STAT_OK;
               end
            end
         end
         REQ_DISCONNECT: begin
            if (evt != 0) begin
               res.status = STAT_IGNORED;
            end else begin
               e = lowest_match(1'b1, key);
               if (e >= 0) begin
                  v = map_virt[e];
                  // the freed entry is the first one holding that virtual handle
                  f = lowest_match(1'b0, v);
                  if (f != e)
                     earlier_frees++;
                  map_valid[f] = 1'b0;
                  res.handle = v;
                  res.status = STAT_OK;
               end
            end
         end
         REQ_REMOVE_VIRT, REQ_VIRT_TO_PHYS: begin
            e = lowest_match(1'b0, key);
            if (e >= 0) begin
               if (kind == REQ_REMOVE_VIRT)
                  map_valid[e] = 1'b0;
               res.handle = map_phys[e];
               res.status = STAT_OK;
            end
         end
         REQ_REMOVE_PHYS, REQ_PHYS_TO_VIRT: begin
            e = lowest_match(1'b1, key);
            if (e >= 0) begin
               if (kind == REQ_REMOVE_PHYS)
                  map_valid[e] = 1'b0;
               res.handle = map_virt[e];
               res.status = STAT_OK;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // mostly a handle that is in the table, sometimes any handle
   function automatic logic [HANDLE_W-1:0] pick_key(input bit by_phys);
      int live [$];
      int idx;
      for (int i = 0; i < ENTRIES; i++)
         if (map_valid[i])
            live.push_back(i);
      if (live.size() == 0 || $urandom_range(0, 3) == 0)
         return HANDLE_W'($urandom_range(0, 4095));
      idx = live[$urandom_range(0, live.size() - 1)];
      return by_phys ? map_phys[idx] : map_virt[idx];
   endfunction

   function automatic stim_row random_request(input traffic_mix mix);
      stim_row r;
      int roll;
      int conn_pct;
      conn_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 10 : 40;
      roll = $urandom_range(0, 99);
      if (roll < conn_pct)
         r.kind = REQ_CONNECT;
      else if (roll < 97)
         r.kind = REQ_W'($urandom_range(REQ_DISCONNECT, REQ_REMOVE_PHYS));
      else
         r.kind = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
      case (r.kind)
         REQ_CONNECT:
            r.handle = ($urandom_range(0, 4) == 0) ? pick_key(1'b1) :
                       HANDLE_W'($urandom_range(0, 4095));
         REQ_DISCONNECT, REQ_PHYS_TO_VIRT, REQ_REMOVE_PHYS:
            r.handle = pick_key(1'b1);
         REQ_REMOVE_VIRT, REQ_VIRT_TO_PHYS:
            r.handle = pick_key(1'b0);
         default:
            r.handle = HANDLE_W'($urandom_range(0, 4095));
      endcase
      r.flags = FLAGS_W'($urandom_range(0, 15));
      if ((r.kind == REQ_CONNECT || r.kind == REQ_DISCONNECT) && $urandom_range(0, 4) != 0)
         r.evt = '0;
      else
         r.evt = EVT_W'($urandom_range(0, 255));
      r.fixed = 1'b0;
      r.want_handle = '0;
      r.want_status = STAT_OK;
      return r;
   endfunction

   // entered at a falling edge, returns at a falling edge after the gap
   task automatic issue(input stim_row r, input int gap);
      table_result res;
      start <= 1'b1;
      req_type <= r.kind;
      req_handle_in <= r.handle;
      req_flags_in <= r.flags;
      req_event_status <= r.evt;
      while (busy)
         @(negedge clock);
      @(posedge clock);
      res = apply_request(r.kind, r.handle, r.flags, r.evt);
      if (r.fixed) begin
         res.handle = r.want_handle;
         res.status = r.want_status;
      end
      awaited_rsp.push_back(res);
      requests_sent++;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin : check_rsp
      table_result want;
      if (!reset && rsp_strobe) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch("unexpected result, handle", rsp_handle_out, 0);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_handle_out !== want.handle)
               report_mismatch("handle_out", rsp_handle_out, want.handle);
            if (rsp_flags_out !== want.flags)
               report_mismatch("flags_out", rsp_flags_out, want.flags);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, awaited_rsp.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      traffic_mix mix;
      int phase;
      int phase_len;
      int gap_max;
      int random_sent;
      for (int i = 0; i < ENTRIES; i++) begin
         map_valid[i] = 1'b0;
         map_virt[i] = '0;
         map_phys[i] = '0;
      end
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i])
         issue(plan[i], $urandom_range(0, 7));

      phase = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         // start with a fill so the table runs full early
         mix = (phase == 0) ? MIX_FILL : traffic_mix'($urandom_range(0, 2));
         phase_len = (phase == 0) ? 45 : $urandom_range(20, 60);
         gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
         for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
            issue(random_request(mix), $urandom_range(0, gap_max));
            random_sent++;
         end
         if (phase == 0 || $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            // hold off until every result is in, so start drops before the next request
            do
               @(negedge clock);
            while (awaited_rsp.size() != 0);
         end
         phase++;
      end

      start <= 1'b0;
      while (awaited_rsp.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("%0d requests over %0d traffic phases; %0d connects, %0d refused on a full table",
               requests_sent, phase, connects_done, full_hits);
      $display("handle counter wrapped %0d times; %0d disconnects freed an earlier entry",
               counter_wraps, earlier_frees);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", errors);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
